// ===== hw/rtl/fsp_pkg.sv =====
// Shared types and constants of the format spec parser.
package fsp_pkg;

  // Parse phase codes
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_MAIN = 4'd1;
  localparam logic [3:0] PH_WDIG = 4'd2;
  localparam logic [3:0] PH_DOT  = 4'd3;
  localparam logic [3:0] PH_PDIG = 4'd4;
  localparam logic [3:0] PH_H    = 4'd5;
  localparam logic [3:0] PH_HH   = 4'd6;
  localparam logic [3:0] PH_L    = 4'd7;
  localparam logic [3:0] PH_LL   = 4'd8;
  localparam logic [3:0] PH_BIGL = 4'd9;
  localparam logic [3:0] PH_SKIP = 4'd10;

  // Characters with a special role
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_STAR = 8'h2a;

  // Saturation limit of width and precision digit runs
  localparam logic [30:0] SAT_MAX = 31'h7fffffff;

  typedef struct packed {
    logic [7:0]         ch;
    logic signed [31:0] arg_value;
    logic               start_req;
  } char_item_t;

  typedef struct packed {
    logic [5:0]         conv_type;
    logic               left_align;
    logic               force_sign;
    logic               space_sign;
    logic               pad_zero;
    logic               flag_alt;
    logic               has_precision;
    logic               has_width;
    logic [30:0]        width;
    logic signed [31:0] precision;
    logic               is_literal_percent;
    logic               char_consumed;
  } spec_result_t;

  typedef struct packed {
    logic [3:0]         phase;
    logic               minus;
    logic               plus;
    logic               space;
    logic               zero;
    logic               alt;
    logic               prec_set;
    logic               wid_set;
    logic [30:0]        width;
    logic signed [31:0] precision;
  } parse_state_t;

endpackage

// ===== hw/rtl/fsp_step.sv =====
// Per-character parse step: next parser state and the result the character ends in.
module fsp_step import fsp_pkg::*; (
  input  char_item_t   item,
  input  parse_state_t cur,
  output parse_state_t nxt,
  output logic         has_res,
  output spec_result_t res
);

  // Conversion letters with no length prefix
  function automatic logic [5:0] conv_plain(input logic [7:0] c);
    case (c)
      "b":     return 6'd1;
      "c":     return 6'd2;
      "f":     return 6'd10;
      "x":     return 6'd11;
      "X":     return 6'd12;
      "d":     return 6'd13;
      "i":     return 6'd13;
      CH_PCT:  return 6'd27;
      "p":     return 6'd28;
      "s":     return 6'd35;
      "S":     return 6'd35;
      "u":     return 6'd36;
      "o":     return 6'd37;
      default: return 6'd0;
    endcase
  endfunction

  // Integer letters after a prefix; base is the code of 'b' for that prefix
  function automatic logic [5:0] prefix_conv(input logic [7:0] c, input logic [5:0] base);
    case (c)
      "b":     return base;
      "x":     return base + 6'd1;
      "X":     return base + 6'd2;
      "d":     return base + 6'd3;
      "i":     return base + 6'd3;
      "u":     return base + 6'd4;
      "o":     return base + 6'd5;
      default: return 6'd0;
    endcase
  endfunction

  // Multiply by ten and add a digit, saturating
  function automatic logic [30:0] sat_acc(input logic [30:0] acc, input logic [3:0] d);
    logic [34:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {31'd0, d};
    return (v > {4'd0, SAT_MAX}) ? SAT_MAX : v[30:0];
  endfunction

  logic [7:0]  c;
  logic [3:0]  dval;
  logic        is_digit;
  logic        is_alnum;
  logic        lit;
  logic        run_main;
  logic        tok_bad;
  logic        fin;
  logic [5:0]  conv;
  logic [3:0]  phase_eff;
  logic [5:0]  k_h;
  logic [5:0]  k_hh;
  logic [5:0]  k_l;
  logic [5:0]  k_ll;
  logic [5:0]  k_plain;
  logic        star_neg;
  logic [31:0] star_mag;

  // Character classes and table lookups
  assign c        = item.ch;
  assign dval     = c[3:0];
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_alnum = is_digit || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign k_h      = prefix_conv(c, 6'd29);
  assign k_hh     = prefix_conv(c, 6'd3);
  assign k_l      = (c == "f") ? 6'd9 : prefix_conv(c, 6'd15);
  assign k_ll     = prefix_conv(c, 6'd21);
  assign k_plain  = conv_plain(c);

  // Star width: zero or negative flips sign and sets left justify
  assign star_neg = item.arg_value[31] || (item.arg_value == 32'sd0);
  assign star_mag = star_neg ? (32'd0 - 32'(item.arg_value)) : 32'(item.arg_value);

  always_comb begin
    nxt       = cur;
    res       = '0;
    has_res   = 1'b0;
    conv      = 6'd0;
    fin       = 1'b0;
    run_main  = 1'b0;
    tok_bad   = 1'b0;
    lit       = 1'b0;
    phase_eff = cur.phase;

    // Restart on the character after the introducing percent
    if (item.start_req) begin
      nxt.minus     = 1'b0;
      nxt.plus      = 1'b0;
      nxt.space     = 1'b0;
      nxt.zero      = 1'b0;
      nxt.alt       = 1'b0;
      nxt.prec_set  = 1'b0;
      nxt.wid_set   = 1'b0;
      nxt.width     = '0;
      nxt.precision = '0;
      nxt.phase     = PH_MAIN;
      phase_eff     = PH_MAIN;
      lit           = (c == CH_PCT);
    end

    // Phase-specific handling
    if (lit) begin
      nxt.phase = PH_IDLE;
    end else begin
      case (phase_eff)
        PH_MAIN: run_main = 1'b1;
        PH_WDIG: begin
          if (is_digit) begin
            nxt.width = sat_acc(nxt.width, dval);
          end else begin
            nxt.phase = PH_MAIN;
            run_main  = 1'b1;
          end
        end
        PH_DOT: begin
          if (c == CH_STAR) begin
            nxt.precision = item.arg_value;
            nxt.phase     = PH_MAIN;
          end else if (is_digit) begin
            nxt.precision = {28'd0, dval};
            nxt.phase     = PH_PDIG;
          end else begin
            nxt.precision = '0;
            nxt.phase     = PH_MAIN;
            run_main      = 1'b1;
          end
        end
        PH_PDIG: begin
          if (is_digit) begin
            nxt.precision = {1'b0, sat_acc(nxt.precision[30:0], dval)};
          end else begin
            nxt.phase = PH_MAIN;
            run_main  = 1'b1;
          end
        end
        PH_H: begin
          if (k_h != 6'd0) begin
            conv = k_h;
            fin  = 1'b1;
          end else if (c == "h") begin
            nxt.phase = PH_HH;
          end else begin
            tok_bad = 1'b1;
          end
        end
        PH_HH: begin
          if (k_hh != 6'd0) begin
            conv = k_hh;
            fin  = 1'b1;
          end else begin
            tok_bad = 1'b1;
          end
        end
        PH_L: begin
          if (k_l != 6'd0) begin
            conv = k_l;
            fin  = 1'b1;
          end else if (c == "l") begin
            nxt.phase = PH_LL;
          end else begin
            tok_bad = 1'b1;
          end
        end
        PH_LL: begin
          if (k_ll != 6'd0) begin
            conv = k_ll;
            fin  = 1'b1;
          end else begin
            tok_bad = 1'b1;
          end
        end
        PH_BIGL: begin
          if (c == "f") begin
            conv = 6'd14;
            fin  = 1'b1;
          end else begin
            tok_bad = 1'b1;
          end
        end
        PH_SKIP: fin = !is_alnum;
        default: nxt.phase = PH_IDLE;
      endcase
    end

    // Main phase: flags, width, dot, prefixes and plain conversions
    if (run_main) begin
      if (c == CH_NUL) begin
        fin = 1'b1;
      end else if (c == "-") begin
        nxt.minus = 1'b1;
      end else if (c == "+") begin
        nxt.plus = 1'b1;
      end else if (c == " ") begin
        nxt.space = 1'b1;
      end else if (c == "0") begin
        nxt.zero = 1'b1;
      end else if (c == "#") begin
        nxt.alt = 1'b1;
      end else if (c == CH_DOT) begin
        nxt.prec_set = 1'b1;
        nxt.phase    = PH_DOT;
      end else if (c == CH_STAR) begin
        nxt.wid_set = 1'b1;
        if (star_neg) begin
          nxt.minus = 1'b1;
        end
        nxt.width = star_mag[31] ? SAT_MAX : star_mag[30:0];
      end else if (c == "h") begin
        nxt.phase = PH_H;
      end else if (c == "l") begin
        nxt.phase = PH_L;
      end else if (c == "L") begin
        nxt.phase = PH_BIGL;
      end else if (is_digit) begin
        nxt.wid_set = 1'b1;
        nxt.width   = {27'd0, dval};
        nxt.phase   = PH_WDIG;
      end else if (k_plain != 6'd0) begin
        conv = k_plain;
        fin  = 1'b1;
      end else begin
        tok_bad = 1'b1;
      end
    end

    // Unknown token: skip its alphanumerics, else end the spec here
    if (tok_bad) begin
      if (is_alnum) begin
        nxt.phase = PH_SKIP;
      end else begin
        fin = 1'b1;
      end
    end

    // Build the result
    if (lit) begin
      has_res                = 1'b1;
      res.is_literal_percent = 1'b1;
      res.char_consumed      = 1'b1;
    end else if (fin) begin
      has_res           = 1'b1;
      res.conv_type     = conv;
      res.left_align    = nxt.minus;
      res.force_sign    = nxt.plus;
      res.space_sign    = nxt.space;
      res.pad_zero      = nxt.zero;
      res.flag_alt      = nxt.alt;
      res.has_precision = nxt.prec_set;
      res.has_width     = nxt.wid_set;
      res.width         = nxt.width;
      res.precision     = nxt.precision;
      res.char_consumed = (conv != 6'd0);
      nxt.phase         = PH_IDLE;
    end
  end

endmodule

// ===== hw/rtl/format_spec_parser.sv =====
// Top level of the format spec parser: input register, parser state and result register.
//
//   Channel | Direction | Handshake              | Payload
//   char    | in        | char_valid, char_stall | char_data (char_item_t)
//   res     | out       | res_valid, res_stall   | res_data (spec_result_t)
//
// One character is taken per cycle while char_stall is low. A character parses while it
// is held in the input register; its result, if any, is registered on res as it advances.
// A single step of decode and multiply-by-ten accumulate handles each character.
// Reset clears the parser to idle with flags, width and precision at zero.
// A stalled result holds the input register only when the next character also
// ends a spec; other characters keep flowing under an output stall.
module format_spec_parser import fsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  output logic         char_stall,
  input  char_item_t   char_data,
  output logic         res_valid,
  input  logic         res_stall,
  output spec_result_t res_data
);

  char_item_t   in_q;
  logic         in_full;
  parse_state_t state;
  parse_state_t state_next;
  logic         step_has;
  spec_result_t step_res;
  logic         advance;

  fsp_step u_step (
    .item    (in_q),
    .cur     (state),
    .nxt     (state_next),
    .has_res (step_has),
    .res     (step_res)
  );

  // Move the held character on unless its result cannot be stored
  assign advance    = in_full && (!step_has || !res_valid || !res_stall);
  assign char_stall = in_full && !advance;

  // Input register: take a transfer whenever not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!char_stall) begin
      in_full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_q <= char_data;
    end
  end

  // Parser state: advance once per processed character
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= PH_IDLE;
      state.minus     <= 1'b0;
      state.plus      <= 1'b0;
      state.space     <= 1'b0;
      state.zero      <= 1'b0;
      state.alt       <= 1'b0;
      state.prec_set  <= 1'b0;
      state.wid_set   <= 1'b0;
      state.width     <= '0;
      state.precision <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: load a new result, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && step_has) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_has) begin
      res_data <= step_res;
    end
  end

  // A character that ends a spec leaves the parser idle
  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    advance && step_has |=> state.phase == PH_IDLE)
    else $error("parser not idle after a result");

  // Input stalls only while a character is held
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> in_full)
    else $error("input stalled with empty register");

  // A stalled result is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> !(advance && step_has))
    else $error("pending result overwritten");

  // A doubled percent carries no conversion and consumes its character
  a_literal_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.is_literal_percent |->
      res_data.conv_type == 6'd0 && res_data.char_consumed)
    else $error("malformed literal percent result");

endmodule

// ===== verif/testbench.sv =====
// Testbench of the format spec parser: directed and random character streams with a spec tracker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned SPEC_ITEMS   = 500;

  localparam logic [7:0] CH_DIG0  = "0";
  localparam logic [7:0] CH_COMMA = ",";

  // Conversion codes, in table order
  localparam logic [5:0] CV_NONE    = 6'd0;
  localparam logic [5:0] CV_B       = 6'd1;
  localparam logic [5:0] CV_C       = 6'd2;
  localparam logic [5:0] CV_HH_BASE = 6'd3;
  localparam logic [5:0] CV_LF      = 6'd9;
  localparam logic [5:0] CV_F       = 6'd10;
  localparam logic [5:0] CV_X       = 6'd11;
  localparam logic [5:0] CV_XU      = 6'd12;
  localparam logic [5:0] CV_D       = 6'd13;
  localparam logic [5:0] CV_BIG_LF  = 6'd14;
  localparam logic [5:0] CV_L_BASE  = 6'd15;
  localparam logic [5:0] CV_LL_BASE = 6'd21;
  localparam logic [5:0] CV_PCT     = 6'd27;
  localparam logic [5:0] CV_P       = 6'd28;
  localparam logic [5:0] CV_H_BASE  = 6'd29;
  localparam logic [5:0] CV_S       = 6'd35;
  localparam logic [5:0] CV_U       = 6'd36;
  localparam logic [5:0] CV_O       = 6'd37;

  localparam string FLAG_CHARS = "-+ #0";
  localparam string PLAIN_CONV = "bcfxXdi%psSuo";
  localparam string INT_CONV   = "bxXdiuo";
  localparam string BAD_CHARS  = "gjkmnqrtvwyzA";

  typedef enum logic [1:0] {STEP_MORE, STEP_CONV, STEP_END} step_t;

  // Tracks the parse of each spec and holds the results still due from the block
  class spec_ledger;
    parse_state_t ps;
    logic [5:0]   conv;
    spec_result_t specs_due[$];
    int unsigned  errors;

    function new();
      ps = '0;
      ps.phase = PH_IDLE;
      conv = CV_NONE;
      errors = 0;
    endfunction

    function bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alnum(logic [7:0] c);
      return is_dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Multiply by ten and add the digit, saturating
    function logic [31:0] dig_accum(logic [31:0] acc, logic [7:0] c);
      logic [63:0] v;
      v = 64'(acc) * 64'd10 + 64'(c - CH_DIG0);
      return (v > 64'(SAT_MAX)) ? {1'b0, SAT_MAX} : v[31:0];
    endfunction

    function logic [5:0] plain_conv(logic [7:0] c);
      case (c)
        "b": return CV_B;
        "c": return CV_C;
        "f": return CV_F;
        "x": return CV_X;
        "X": return CV_XU;
        "d", "i": return CV_D;
        "%": return CV_PCT;
        "p": return CV_P;
        "s", "S": return CV_S;
        "u": return CV_U;
        "o": return CV_O;
        default: return CV_NONE;
      endcase
    endfunction

    // Integer letters after a length prefix run b x X d u o from the prefix's base
    function logic [5:0] int_conv(logic [7:0] c, logic [5:0] base);
      case (c)
        "b": return base;
        "x": return base + 6'd1;
        "X": return base + 6'd2;
        "d", "i": return base + 6'd3;
        "u": return base + 6'd4;
        "o": return base + 6'd5;
        default: return CV_NONE;
      endcase
    endfunction

    function step_t unknown_tok(logic [7:0] c);
      if (is_alnum(c)) begin
        ps.phase = PH_SKIP;
        return STEP_MORE;
      end
      return STEP_END;
    endfunction

    function step_t main_step(logic [7:0] c, logic signed [31:0] arg);
      longint     mag;
      logic [5:0] k;
      if (c == CH_NUL) return STEP_END;
      case (c)
        "-": begin
          ps.minus = 1'b1;
          return STEP_MORE;
        end
        "+": begin
          ps.plus = 1'b1;
          return STEP_MORE;
        end
        " ": begin
          ps.space = 1'b1;
          return STEP_MORE;
        end
        "0": begin
          ps.zero = 1'b1;
          return STEP_MORE;
        end
        "#": begin
          ps.alt = 1'b1;
          return STEP_MORE;
        end
        CH_DOT: begin
          ps.prec_set = 1'b1;
          ps.phase = PH_DOT;
          return STEP_MORE;
        end
        CH_STAR: begin
          // Zero or negative star width flips to its magnitude and left justifies
          mag = longint'(arg);
          ps.wid_set = 1'b1;
          if (mag <= 0) begin
            ps.minus = 1'b1;
            mag = -mag;
          end
          ps.width = (mag > longint'(SAT_MAX)) ? SAT_MAX : mag[30:0];
          return STEP_MORE;
        end
        "h": begin
          ps.phase = PH_H;
          return STEP_MORE;
        end
        "l": begin
          ps.phase = PH_L;
          return STEP_MORE;
        end
        "L": begin
          ps.phase = PH_BIGL;
          return STEP_MORE;
        end
        default: ;
      endcase
      if (is_dig(c)) begin
        ps.wid_set = 1'b1;
        ps.width = 31'(c - CH_DIG0);
        ps.phase = PH_WDIG;
        return STEP_MORE;
      end
      k = plain_conv(c);
      if (k != CV_NONE) begin
        conv = k;
        return STEP_CONV;
      end
      return unknown_tok(c);
    endfunction

    function step_t prefix_step(logic [7:0] c, logic [5:0] k, logic [3:0] next_ph,
                                logic [7:0] twin);
      if (k != CV_NONE) begin
        conv = k;
        return STEP_CONV;
      end
      if (twin != CH_NUL && c == twin) begin
        ps.phase = next_ph;
        return STEP_MORE;
      end
      return unknown_tok(c);
    endfunction

    // Advance the parse by one accepted character; queue the result it ends with
    function void take_char(char_item_t it);
      logic [7:0]   c;
      logic [31:0]  acc;
      step_t        s;
      spec_result_t r;
      c = it.ch;
      conv = CV_NONE;
      r = '0;
      if (it.start_req) begin
        ps = '0;
        ps.phase = PH_MAIN;
        if (c == CH_PCT) begin
          ps.phase = PH_IDLE;
          r.is_literal_percent = 1'b1;
          r.char_consumed = 1'b1;
          specs_due.push_back(r);
          return;
        end
      end
      case (ps.phase)
        PH_MAIN: s = main_step(c, it.arg_value);
        PH_WDIG: begin
          if (is_dig(c)) begin
            acc = dig_accum({1'b0, ps.width}, c);
            ps.width = acc[30:0];
            s = STEP_MORE;
          end else begin
            ps.phase = PH_MAIN;
            s = main_step(c, it.arg_value);
          end
        end
        PH_DOT: begin
          if (c == CH_STAR) begin
            ps.precision = it.arg_value;
            ps.phase = PH_MAIN;
            s = STEP_MORE;
          end else if (is_dig(c)) begin
            ps.precision = 32'(c - CH_DIG0);
            ps.phase = PH_PDIG;
            s = STEP_MORE;
          end else begin
            ps.precision = '0;
            ps.phase = PH_MAIN;
            s = main_step(c, it.arg_value);
          end
        end
        PH_PDIG: begin
          if (is_dig(c)) begin
            ps.precision = dig_accum(ps.precision, c);
            s = STEP_MORE;
          end else begin
            ps.phase = PH_MAIN;
            s = main_step(c, it.arg_value);
          end
        end
        PH_H:    s = prefix_step(c, int_conv(c, CV_H_BASE), PH_HH, "h");
        PH_HH:   s = prefix_step(c, int_conv(c, CV_HH_BASE), PH_HH, CH_NUL);
        PH_L:    s = prefix_step(c, (c == "f") ? CV_LF : int_conv(c, CV_L_BASE), PH_LL, "l");
        PH_LL:   s = prefix_step(c, int_conv(c, CV_LL_BASE), PH_LL, CH_NUL);
        PH_BIGL: s = prefix_step(c, (c == "f") ? CV_BIG_LF : CV_NONE, PH_BIGL, CH_NUL);
        PH_SKIP: s = is_alnum(c) ? STEP_MORE : STEP_END;
        default: begin
          ps.phase = PH_IDLE;
          return;
        end
      endcase
      if (s == STEP_MORE) return;
      r.conv_type     = (s == STEP_CONV) ? conv : CV_NONE;
      r.left_align    = ps.minus;
      r.force_sign    = ps.plus;
      r.space_sign    = ps.space;
      r.pad_zero      = ps.zero;
      r.flag_alt      = ps.alt;
      r.has_precision = ps.prec_set;
      r.has_width     = ps.wid_set;
      r.width         = ps.width;
      r.precision     = ps.precision;
      r.char_consumed = (s == STEP_CONV);
      ps.phase = PH_IDLE;
      specs_due.push_back(r);
    endfunction

    function void field_cmp(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
      end
    endfunction

    // Compare one accepted result with the oldest one due
    function void match_result(spec_result_t got);
      spec_result_t want;
      if (specs_due.size() == 0) begin
        errors++;
        $display("%0t: result with none due, expected nothing, got %p", $time, got);
        return;
      end
      want = specs_due.pop_front();
      field_cmp("conv_type", 32'(want.conv_type), 32'(got.conv_type));
      field_cmp("left_align", 32'(want.left_align), 32'(got.left_align));
      field_cmp("force_sign", 32'(want.force_sign), 32'(got.force_sign));
      field_cmp("space_sign", 32'(want.space_sign), 32'(got.space_sign));
      field_cmp("pad_zero", 32'(want.pad_zero), 32'(got.pad_zero));
      field_cmp("flag_alt", 32'(want.flag_alt), 32'(got.flag_alt));
      field_cmp("has_precision", 32'(want.has_precision), 32'(got.has_precision));
      field_cmp("has_width", 32'(want.has_width), 32'(got.has_width));
      field_cmp("width", 32'(want.width), 32'(got.width));
      field_cmp("precision", want.precision, got.precision);
      field_cmp("is_literal_percent", 32'(want.is_literal_percent),
                32'(got.is_literal_percent));
      field_cmp("char_consumed", 32'(want.char_consumed), 32'(got.char_consumed));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  logic         char_valid;
  logic         char_stall;
  char_item_t   char_data;
  logic         res_valid;
  logic         res_stall;
  spec_result_t res_data;

  spec_ledger  ledger = new();
  bit          calm = 1'b0;
  int unsigned cycles = 0;

  format_spec_parser u_top (
    .clk,
    .rst,
    .char_valid,
    .char_stall,
    .char_data,
    .res_valid,
    .res_stall,
    .res_data
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("format_spec_parser verification failed");
      $finish;
    end
  end

  // Track every transfer on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && !char_stall) ledger.take_char(char_data);
      if (res_valid && !res_stall) ledger.match_result(res_data);
    end
  end

  // Idle lengths: mostly none or short, a few long, none during calm stretches
  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] rand_arg();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_DIG0 + 8'($urandom_range(0, 9));
  endfunction

  // Present one character and hold it until the transfer
  task automatic push_char(input logic [7:0] c, input logic signed [31:0] arg,
                           input logic start);
    int unsigned gap;
    char_item_t  it;
    gap = gap_len();
    if (gap != 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.ch = c;
    it.arg_value = arg;
    it.start_req = start;
    char_valid <= 1'b1;
    char_data <= it;
    @(posedge clk);
    while (char_stall) @(posedge clk);
  endtask

  task automatic send_str(input string s, input logic signed [31:0] arg);
    for (int i = 0; i < s.len(); i++) push_char(s[i], arg, i == 0);
  endtask

  // Build one spec, mostly well formed, and send it; return its length
  task automatic send_spec(output int unsigned n);
    logic [7:0]  body[$];
    string       letters;
    int unsigned ending;
    body = {};
    repeat ($urandom_range(0, 3)) body.push_back(FLAG_CHARS[$urandom_range(0, 4)]);
    case ($urandom_range(0, 5))
      0, 1: ;
      2: body.push_back(CH_STAR);
      3: repeat ($urandom_range(9, 11)) body.push_back(rand_digit());
      default: repeat ($urandom_range(1, 3)) body.push_back(rand_digit());
    endcase
    if ($urandom_range(0, 1) == 1) begin
      body.push_back(CH_DOT);
      case ($urandom_range(0, 5))
        0, 1: ;
        2: body.push_back(CH_STAR);
        3: repeat ($urandom_range(9, 11)) body.push_back(rand_digit());
        default: repeat ($urandom_range(1, 3)) body.push_back(rand_digit());
      endcase
    end
    case ($urandom_range(0, 7))
      0: begin
        body.push_back("h");
        letters = INT_CONV;
      end
      1: begin
        body.push_back("h");
        body.push_back("h");
        letters = INT_CONV;
      end
      2: begin
        body.push_back("l");
        letters = {INT_CONV, "f"};
      end
      3: begin
        body.push_back("l");
        body.push_back("l");
        letters = INT_CONV;
      end
      4: begin
        body.push_back("L");
        letters = "f";
      end
      default: letters = PLAIN_CONV;
    endcase
    // Close with a letter, the end of the string, an unknown token, or nothing at all
    ending = $urandom_range(0, 19);
    if (ending == 0) begin
      body.push_back(CH_NUL);
    end else if (ending <= 2) begin
      body.push_back(BAD_CHARS[$urandom_range(0, BAD_CHARS.len() - 1)]);
      repeat ($urandom_range(0, 2)) body.push_back(rand_digit());
      body.push_back(CH_COMMA);
    end else if (ending > 3) begin
      body.push_back(letters[$urandom_range(0, letters.len() - 1)]);
    end
    if (body.size() == 0) body.push_back(CH_STAR);
    foreach (body[i]) push_char(body[i], rand_arg(), i == 0);
    n = body.size();
  endtask

  // Drive the character channel
  initial begin
    int unsigned sent;
    int unsigned n;
    rst <= 1'b1;
    char_valid <= 1'b0;
    char_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: doubled percent, idle character, all flags with extreme star values,
    // saturated width with a bare dot, unknown token after a prefix, restart
    // mid-spec, end of string after a zero star width
    push_char(CH_PCT, -32'sd1, 1'b1);
    push_char(8'hff, 32'sh7fff_ffff, 1'b0);
    send_str("-+ #0*.*lld", 32'sh8000_0000);
    send_str("3000000000.Lf", 32'sh7fff_ffff);
    send_str("hqz,", 32'sd0);
    send_str("5", 32'sd0);
    send_str("x", 32'sd0);
    send_str("*", 32'sd0);
    push_char(CH_NUL, 32'sd0, 1'b0);
    send_str("*o", 32'sh7fff_ffff);

    // Random: mostly well-formed specs, some noise, some stray idle characters
    sent = 0;
    while (sent < SPEC_ITEMS) begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      if ($urandom_range(0, 9) < 8) begin
        send_spec(n);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) push_char(8'($urandom_range(0, 255)), rand_arg(),
                             $urandom_range(0, 3) == 0);
      end
      sent += n;
      if ($urandom_range(0, 9) < 3) begin
        n = $urandom_range(1, 3);
        repeat (n) push_char(8'($urandom_range(0, 255)), rand_arg(), 1'b0);
        sent += n;
      end
    end

    // Drain
    char_valid <= 1'b0;
    @(posedge clk);
    while (ledger.specs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("format_spec_parser verification clean");
    end else begin
      $display("format_spec_parser verification failed");
    end
    $finish;
  end

  // Stall the result channel at random
  initial begin
    int unsigned hold;
    forever begin
      hold = gap_len();
      if (hold != 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

endmodule
